// ===== src/sma_pkg.sv =====
// Shared constants and controller/datapath interface types for the smoothed moving average.
`timescale 1ns / 1ps

package sma_pkg;

    // Width of the period register, fixed by the configuration port.
    localparam int PERIOD_W = 11;

    // Period after reset.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(30);

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int MAX_PERIOD_DEF   = 1024;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;  // capture the accepted sample
        logic seed_add;  // add the accepted sample into the seed sum
        logic use_seed;  // dividend comes from the seed sum, not the smoothing sum
        logic mul;       // form last_average * (period - 1)
        logic load_num;  // register the signed dividend
        logic div_init;  // split the dividend into sign and magnitude, clear the divider
        logic div_step;  // one restoring division step
        logic emit_avg;  // load a valid average into the output register
        logic emit_nan;  // load an invalid result into the output register
    } sma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [PERIOD_W-1:0] period_eff; // period after clamping to 1..MAX_PERIOD, at most 2047
        logic                div_last;   // the current step is the final one
        logic                out_free;   // the output register can take a beat
    } sma_sts_t;

endpackage

// ===== src/sma_ctrl.sv =====
// Controller state machine of the smoothed moving average: seeding, poisoning and sequencing.
`timescale 1ns / 1ps

module sma_ctrl
    import sma_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_present,
    output logic     in_ready,
    input  sma_sts_t sts,
    output sma_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_ABS,
        ST_DIV,
        ST_RES,
        ST_NAN
    } state_t;

    state_t              state_reg, state_next;
    logic [PERIOD_W-1:0] warm_count_reg, warm_count_next;
    logic                poisoned_reg, poisoned_next;
    logic                first_seen_reg, first_seen_next;
    logic                src_seed_reg, src_seed_next;

    logic                accept;
    logic                drop;
    logic                take;
    logic                seeding;
    logic                seed_done;
    logic                poison_now;
    logic [PERIOD_W:0]   warm_inc;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_ready && in_valid;
    assign drop       = accept && !first_seen_reg && !in_present;
    assign take       = accept && !drop;
    assign poison_now = poisoned_reg || !in_present;
    assign warm_inc   = {1'b0, warm_count_reg} + (PERIOD_W + 1)'(1);
    assign seeding    = (warm_count_reg < sts.period_eff);
    assign seed_done  = (warm_inc == {1'b0, sts.period_eff});

    always_comb
    begin
        cmd          = '0;
        cmd.latch_in = take;
        cmd.seed_add = take && seeding && in_present;
        cmd.use_seed = src_seed_reg;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.load_num = (state_reg == ST_SUM);
        cmd.div_init = (state_reg == ST_ABS);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.emit_avg = (state_reg == ST_RES) && sts.out_free;
        cmd.emit_nan = (state_reg == ST_NAN) && sts.out_free;
    end

    always_comb
    begin
        state_next      = state_reg;
        warm_count_next = warm_count_reg;
        poisoned_next   = poisoned_reg;
        first_seen_next = first_seen_reg;
        src_seed_next   = src_seed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (drop)
                begin
                    first_seen_next = 1'b1;
                end
                else if (take)
                begin
                    first_seen_next = 1'b1;
                    poisoned_next   = poison_now;
                    if (seeding)
                    begin
                        warm_count_next = warm_inc[PERIOD_W-1:0];
                        if (seed_done && !poison_now)
                        begin
                            src_seed_next = 1'b1;
                            state_next    = ST_SUM;
                        end
                        else
                        begin
                            state_next = ST_NAN;
                        end
                    end
                    else if (!poison_now)
                    begin
                        src_seed_next = 1'b0;
                        state_next    = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_NAN;
                    end
                end
            end
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES, ST_NAN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            warm_count_reg <= '0;
            poisoned_reg   <= 1'b0;
            first_seen_reg <= 1'b0;
            src_seed_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            warm_count_reg <= warm_count_next;
            poisoned_reg   <= poisoned_next;
            first_seen_reg <= first_seen_next;
            src_seed_reg   <= src_seed_next;
        end
    end

    // Once an absent sample has been taken (not dropped) the block stays poisoned.
    a_poison_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        poisoned_reg |=> poisoned_reg)
        else $error("poisoned flag cleared without reset");

    // A result only follows a finished division.
    a_res_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES) |-> ($past(state_reg) == ST_DIV || $past(state_reg) == ST_RES))
        else $error("result state entered without a division");

    // A poisoned block never starts a division.
    a_no_div_poisoned: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && poisoned_reg) |=> (state_reg == ST_IDLE || state_reg == ST_NAN))
        else $error("division started on a poisoned block");

endmodule

// ===== src/sma_dp.sv =====
// Datapath of the smoothed moving average: seed sum, multiplier, serial divider, output register.
`timescale 1ns / 1ps

module sma_dp
    import sma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int MAX_PERIOD   = MAX_PERIOD_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [PERIOD_W-1:0]            cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [SAMPLE_WIDTH-1:0] average,
    output logic                           average_valid,
    input  sma_cmd_t                       cmd,
    output sma_sts_t                       sts
);

    localparam int DIV_W  = SAMPLE_WIDTH + PERIOD_W + 1;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int PCLAMP = (MAX_PERIOD > (1 << PERIOD_W) - 1) ? (1 << PERIOD_W) - 1
                                                                : MAX_PERIOD;

    logic [PERIOD_W-1:0]            period_reg;
    logic [PERIOD_W-1:0]            p_eff;
    logic [PERIOD_W-1:0]            p_minus1;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [DIV_W-1:0]        seed_sum_reg;
    logic signed [SAMPLE_WIDTH-1:0] last_reg;
    logic signed [DIV_W-1:0]        prod_reg;
    logic signed [DIV_W-1:0]        num_reg;
    logic                           neg_reg;
    logic [DIV_W-1:0]               quo_reg;
    logic [PERIOD_W-1:0]            rem_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_avg_reg;
    logic                           out_flag_reg;

    logic [PERIOD_W:0]              trial;
    logic                           fits;
    logic [DIV_W-1:0]               quo_signed;

    always_comb
    begin
        priority if (period_reg == '0)
            p_eff = PERIOD_W'(1);
        else if (period_reg > PERIOD_W'(PCLAMP))
            p_eff = PERIOD_W'(PCLAMP);
        else
            p_eff = period_reg;
    end

    assign p_minus1   = p_eff - PERIOD_W'(1);
    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign fits       = (trial >= {1'b0, p_eff});
    assign quo_signed = neg_reg ? (~quo_reg + DIV_W'(1)) : quo_reg;

    assign sts.period_eff = p_eff;
    assign sts.div_last   = (cnt_reg == CNT_W'(DIV_W - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign average       = out_avg_reg;
    assign average_valid = out_flag_reg;

    // Control state: period register, seed sum, last average, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            seed_sum_reg  <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                period_reg <= cfg_data;
            end
            if (cmd.seed_add)
            begin
                seed_sum_reg <= seed_sum_reg + DIV_W'(sample);
            end
            if (cmd.emit_avg)
            begin
                last_reg <= quo_signed[SAMPLE_WIDTH-1:0];
            end
            if (cmd.emit_avg || cmd.emit_nan)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            x_reg <= sample;
        end
        if (cmd.mul)
        begin
            // Both factors are sign-extended first so that the full product is kept.
            prod_reg <= DIV_W'(last_reg) * DIV_W'($signed({1'b0, p_minus1}));
        end
        if (cmd.load_num)
        begin
            num_reg <= cmd.use_seed ? seed_sum_reg : (prod_reg + DIV_W'(x_reg));
        end
        if (cmd.div_init)
        begin
            neg_reg <= num_reg[DIV_W-1];
            quo_reg <= num_reg[DIV_W-1] ? (~num_reg + DIV_W'(1)) : num_reg;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= fits ? PERIOD_W'(trial - {1'b0, p_eff}) : trial[PERIOD_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (cmd.emit_avg)
        begin
            out_avg_reg  <= quo_signed[SAMPLE_WIDTH-1:0];
            out_flag_reg <= 1'b1;
        end
        else if (cmd.emit_nan)
        begin
            out_avg_reg  <= '0;
            out_flag_reg <= 1'b0;
        end
    end

    // An invalid result always carries a zero average.
    a_nan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_flag_reg) |-> (out_avg_reg == '0))
        else $error("invalid result with non-zero average");

endmodule

// ===== src/smoothed_moving_average.sv =====
// Top level of the smoothed moving average: ports, packing and submodule wiring.
`timescale 1ns / 1ps

// Smoothed moving average over a stream of signed fixed-point samples. Each input
// beat carries one sample in s_tdata and, in s_tuser, a flag that is low when the sample is
// missing (NaN). A missing very first sample after reset is dropped and gives no result;
// every other beat gives exactly one result beat. The first `period` samples form the seed:
// each of them but the last gives an invalid result, and the last gives their mean. From
// then on each result is (previous * (period - 1) + sample) / period. All divisions truncate
// toward zero. A missing sample makes that result and all later ones invalid until reset;
// an invalid result carries a zero average and a low m_tuser. The period is written through
// the cfg channel, which is always ready; zero is taken as one and values above MAX_PERIOD
// are clamped. Write it only while the block is idle. The block works on one sample at a
// time. A beat yielding a valid average passes through accept, a multiply step, two steps
// forming the signed dividend, SAMPLE_WIDTH + 12 steps of the bit-serial restoring
// divider, one quotient bit per cycle, and a load of the result. The beat closing the seed
// skips the multiply; a beat with an invalid result goes from accept straight to the load.
// The load waits while the output register holds an unread result; that register lets a
// new beat be accepted while the previous result still waits for m_tready. The fraction
// width of the samples takes no part in the arithmetic, since both steps are linear.
module smoothed_moving_average
    import sma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int MAX_PERIOD   = MAX_PERIOD_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Period register write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [PERIOD_W-1:0]                cfg_data,
    // Input beats.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    input  logic                               s_tuser,   // sample_valid
    // Result beats.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  m_tdata,   // [SAMPLE_WIDTH-1:0] average
    output logic                               m_tuser    // average_valid
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    sma_cmd_t                       cmd;
    sma_sts_t                       sts;
    logic signed [SAMPLE_WIDTH-1:0] average;

    // The period register takes a write in every cycle.
    assign cfg_ready = 1'b1;

    // Average is zero-filled up to whole bytes.
    assign m_tdata = TDATA_W'($unsigned(average));

    sma_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_present (s_tuser),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    sma_dp
    #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_PERIOD   (MAX_PERIOD)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .sample        ($signed(s_tdata[SAMPLE_WIDTH-1:0])),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .average       (average),
        .average_valid (m_tuser),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
